@@ rtl/kts_pkg.sv @@
package kts_pkg;

  localparam int TableDepth = 16;
  localparam int KeyW       = 32;
  localparam int ScoreW     = 32;
  localparam int CountW     = 5;
  localparam int CapW       = 5;
  localparam int StatusW    = 3;

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef enum logic [StatusW-1:0] {
    StRaised    = 3'd0,
    StNotHigher = 3'd1,
    StAdded     = 3'd2,
    StReplaced  = 3'd3,
    StRejected  = 3'd4,
    StList      = 3'd5,
    StEmpty     = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    OpAdd  = 1'b0,
    OpList = 1'b1
  } op_e;

endpackage

@@ rtl/keyed_top_k_score_table_core.sv @@
// Keyed top-k score table. Holds up to capacity (key, score) entries (a capacity of 0
// acts as 1, one above the depth as the depth) in a single-port memory, sorted
// ascending by score; entry 0 is the lowest. On a tie an appended entry goes above the
// entries of equal score and a raised or replacing entry stays below them. An add
// (op 0) takes one item at a time: a pipelined key search over the N entries held, a
// decide step, then a walk that moves the new or raised entry into place with one
// memory read and one compare and write through the shared signed comparator per
// entry passed, closed by a write at the table edge or by a read and a write at the
// first entry that stays, and a result state. The sequencer then returns to idle
// before it takes the next item. A list (op 1) reads the table from the top, one read
// and one send per entry, and sends one item per entry, highest score first; an empty
// table gives one item with status empty. The input is stalled for the whole of an
// item. Result items leave through an output register, so a stalled output only holds
// the sequencer when the next result is ready. The capacity register is taken only
// while the block is idle and needs no clearing pass after reset: only entries below
// the fill count are ever read.
module keyed_top_k_score_table_core #(
  parameter int TABLE_DEPTH = kts_pkg::TableDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kts_pkg::CapW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [kts_pkg::KeyW-1:0]    player_key_i,
  input  logic signed [kts_pkg::ScoreW-1:0] score_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kts_pkg::StatusW-1:0] status_o,
  output logic [kts_pkg::KeyW-1:0]    entry_key_o,
  output logic signed [kts_pkg::ScoreW-1:0] entry_score_o,
  output logic [kts_pkg::CountW-1:0]  entry_count_o,
  output logic                        last_o
);
  import kts_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PtrW = (IdxW + 1 > CountW) ? IdxW + 1 : CountW;

  typedef enum logic [7:0] {
    SIdle   = 8'b0000_0001,
    SSearch = 8'b0000_0010,
    SDecide = 8'b0000_0100,
    SWalkRd = 8'b0000_1000,
    SWalkEv = 8'b0001_0000,
    SResp   = 8'b0010_0000,
    SListRd = 8'b0100_0000,
    SListEv = 8'b1000_0000
  } state_e;

  logic [KeyW-1:0]          key_mem   [TABLE_DEPTH];
  logic signed [ScoreW-1:0] score_mem [TABLE_DEPTH];

  state_e                   state_q, state_d;
  logic [CountW-1:0]        count_q, count_d;
  logic [CapW-1:0]          capacity_q;
  logic                     ev_v_q, ev_v_d;
  logic                     out_valid_q, out_valid_d;

  logic [KeyW-1:0]          key_q;
  logic signed [ScoreW-1:0] score_q;
  logic [PtrW-1:0]          ptr_q, ptr_d;
  logic [IdxW-1:0]          j_q, j_d;
  logic                     dir_q, dir_d;
  logic                     found_q, found_d;
  logic [IdxW-1:0]          hit_idx_q, hit_idx_d;
  logic signed [ScoreW-1:0] hit_score_q, hit_score_d;
  logic [IdxW-1:0]          ev_idx_q, ev_idx_d;
  status_e                  status_q, status_d;
  logic [KeyW-1:0]          lo_key_q;
  logic signed [ScoreW-1:0] lo_score_q;
  logic [KeyW-1:0]          rd_key_q;
  logic signed [ScoreW-1:0] rd_score_q;

  logic [StatusW-1:0]       out_status_q, out_status_d;
  logic [KeyW-1:0]          out_key_q, out_key_d;
  logic signed [ScoreW-1:0] out_score_q, out_score_d;
  logic [CountW-1:0]        out_count_q, out_count_d;
  logic                     out_last_q, out_last_d;

  logic                     re, we;
  logic [IdxW-1:0]          ra, wa;
  logic [KeyW-1:0]          wd_key;
  logic signed [ScoreW-1:0] wd_score;

  logic signed [ScoreW-1:0] cmp_a, cmp_b;
  logic                     cmp_lt;

  logic [PtrW-1:0]          cap_ext, depth_ext, cap_lim;
  logic                     full;
  logic                     out_free, out_load;
  logic                     in_acc;
  logic                     right_more;
  logic [IdxW-1:0]          j_up, j_dn;

  assign cmp_lt = cmp_a < cmp_b;

  assign cap_ext   = PtrW'(capacity_q);
  assign depth_ext = PtrW'(TABLE_DEPTH);
  assign cap_lim   = (cap_ext == '0) ? PtrW'(1) : ((cap_ext > depth_ext) ? depth_ext : cap_ext);
  assign full      = PtrW'(count_q) >= cap_lim;

  assign in_stall_o  = (state_q != SIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == SIdle);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign j_up       = j_q + IdxW'(1);
  assign j_dn       = j_q - IdxW'(1);
  assign right_more = (PtrW'(j_q) + PtrW'(1)) < PtrW'(count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ev_v_d       = 1'b0;
    ev_idx_d     = ev_idx_q;
    ptr_d        = ptr_q;
    j_d          = j_q;
    dir_d        = dir_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_score_d  = hit_score_q;
    status_d     = status_q;
    re           = 1'b0;
    ra           = '0;
    we           = 1'b0;
    wa           = j_q;
    wd_key       = key_q;
    wd_score     = score_q;
    cmp_a        = rd_score_q;
    cmp_b        = score_q;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_score_d  = out_score_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          if (op_e'(op_i) == OpList) begin
            if (count_q == '0) begin
              status_d = StEmpty;
              state_d  = SResp;
            end else begin
              ptr_d   = PtrW'(count_q) - PtrW'(1);
              state_d = SListRd;
            end
          end else begin
            ptr_d   = '0;
            found_d = 1'b0;
            state_d = SSearch;
          end
        end
      end
      SSearch: begin
        if (ptr_q < PtrW'(count_q)) begin
          re       = 1'b1;
          ra       = ptr_q[IdxW-1:0];
          ev_v_d   = 1'b1;
          ev_idx_d = ptr_q[IdxW-1:0];
          ptr_d    = ptr_q + PtrW'(1);
        end else if (!ev_v_q) begin
          state_d = SDecide;
        end
        if (ev_v_q && rd_key_q == key_q) begin
          found_d     = 1'b1;
          hit_idx_d   = ev_idx_q;
          hit_score_d = rd_score_q;
        end
      end
      SDecide: begin
        priority if (found_q) begin
          cmp_a = hit_score_q;
          if (cmp_lt) begin
            j_d      = hit_idx_q;
            dir_d    = 1'b1;
            status_d = StRaised;
            state_d  = SWalkRd;
          end else begin
            status_d = StNotHigher;
            state_d  = SResp;
          end
        end else if (!full) begin
          j_d      = IdxW'(count_q);
          dir_d    = 1'b0;
          count_d  = count_q + CountW'(1);
          status_d = StAdded;
          state_d  = SWalkRd;
        end else begin
          cmp_a = lo_score_q;
          if (cmp_lt) begin
            j_d      = '0;
            dir_d    = 1'b1;
            status_d = StReplaced;
            state_d  = SWalkRd;
          end else begin
            status_d = StRejected;
            state_d  = SResp;
          end
        end
      end
      SWalkRd: begin
        if (dir_q ? right_more : (j_q != '0)) begin
          re      = 1'b1;
          ra      = dir_q ? j_up : j_dn;
          state_d = SWalkEv;
        end else begin
          we      = 1'b1;
          state_d = SResp;
        end
      end
      SWalkEv: begin
        if (!dir_q) begin
          cmp_a = score_q;
          cmp_b = rd_score_q;
        end
        we = 1'b1;
        if (cmp_lt) begin
          wd_key   = rd_key_q;
          wd_score = rd_score_q;
          j_d      = dir_q ? j_up : j_dn;
          state_d  = SWalkRd;
        end else begin
          state_d = SResp;
        end
      end
      SResp: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_key_d    = (status_q == StEmpty) ? '0 : lo_key_q;
          out_score_d  = (status_q == StEmpty) ? '0 : lo_score_q;
          out_count_d  = count_q;
          out_last_d   = 1'b1;
          state_d      = SIdle;
        end
      end
      SListRd: begin
        re      = 1'b1;
        ra      = ptr_q[IdxW-1:0];
        state_d = SListEv;
      end
      SListEv: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = StList;
          out_key_d    = rd_key_q;
          out_score_d  = rd_score_q;
          out_count_d  = count_q;
          out_last_d   = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = SIdle;
          end else begin
            ptr_d   = ptr_q - PtrW'(1);
            state_d = SListRd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      capacity_q  <= CapReset;
      ev_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ev_v_q      <= ev_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q   <= player_key_i;
      score_q <= score_i;
    end
    ptr_q        <= ptr_d;
    j_q          <= j_d;
    dir_q        <= dir_d;
    found_q      <= found_d;
    hit_idx_q    <= hit_idx_d;
    hit_score_q  <= hit_score_d;
    ev_idx_q     <= ev_idx_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_score_q  <= out_score_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
    if (we && wa == '0) begin
      lo_key_q   <= wd_key;
      lo_score_q <= wd_score;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa]   <= wd_key;
      score_mem[wa] <= wd_score;
    end
    if (re) begin
      rd_key_q   <= key_mem[ra];
      rd_score_q <= score_mem[ra];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_key_o   = out_key_q;
  assign entry_score_o = out_score_q;
  assign entry_count_o = out_count_q;
  assign last_o        = out_last_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != SIdle)
    else $error("accepted item left the sequencer idle");

  a_write_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> PtrW'(wa) < PtrW'(count_q))
    else $error("table write at or beyond fill count");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CountW'(1)))
    else $error("fill count moved by more than one");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PtrW'(count_q) <= depth_ext)
    else $error("fill count exceeds table depth");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import kts_pkg::*;

  localparam int Depth      = TableDepth;
  localparam int SettleCyc  = 4 * Depth + 16;
  localparam int CycleLimit = 1000000;
  localparam int CalmTail   = 60;
  localparam int PoolSize   = 24;

  typedef enum logic [1:0] {
    KindItem,
    KindCapWrite,
    KindWaitIdle
  } stim_kind_e;

  typedef struct {
    stim_kind_e               kind;
    op_e                      op;
    logic [KeyW-1:0]          key;
    logic signed [ScoreW-1:0] score;
    logic [CapW-1:0]          cap;
  } stim_t;

  typedef struct {
    status_e                  status;
    logic [KeyW-1:0]          key;
    logic signed [ScoreW-1:0] score;
    logic [CountW-1:0]        count;
    logic                     last;
  } score_row_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CapW-1:0]          cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic                     op         = 1'b0;
  logic [KeyW-1:0]          player_key = '0;
  logic signed [ScoreW-1:0] score      = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [StatusW-1:0]       status;
  logic [KeyW-1:0]          entry_key;
  logic signed [ScoreW-1:0] entry_score;
  logic [CountW-1:0]        entry_count;
  logic                     last;

  keyed_top_k_score_table_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .player_key_i  (player_key),
    .score_i       (score),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .entry_key_o   (entry_key),
    .entry_score_o (entry_score),
    .entry_count_o (entry_count),
    .last_o        (last)
  );

  always #5 clk = ~clk;

  logic [KeyW-1:0]          rank_key   [Depth];
  logic signed [ScoreW-1:0] rank_score [Depth];
  int                       rank_fill = 0;
  logic [CapW-1:0]          cap_reg   = CapReset;
  score_row_t               row_q [$];

  stim_t      stim_q [$];
  score_row_t got_row;
  bit         in_taken, cfg_taken, nx_in_valid, nx_cfg_valid;
  int         send_gap    = 0;
  int         recv_gap    = 0;
  int         settle_left = SettleCyc;
  int         errors      = 0;
  int         cycles      = 0;

  function automatic void resort_ranks();
    int                       j;
    logic [KeyW-1:0]          k;
    logic signed [ScoreW-1:0] s;
    for (int i = 1; i < rank_fill; i++) begin
      k = rank_key[i];
      s = rank_score[i];
      j = i;
      while (j > 0 && rank_score[j-1] > s) begin
        rank_key[j]   = rank_key[j-1];
        rank_score[j] = rank_score[j-1];
        j--;
      end
      rank_key[j]   = k;
      rank_score[j] = s;
    end
  endfunction

  function automatic void rank_offer(op_e o, logic [KeyW-1:0] k, logic signed [ScoreW-1:0] s);
    int         lim;
    int         hit;
    status_e    st;
    score_row_t row;
    if (o == OpList) begin
      if (rank_fill == 0) begin
        row = '{StEmpty, '0, '0, '0, 1'b1};
        row_q = {row_q, row};
      end else begin
        for (int i = rank_fill - 1; i >= 0; i--) begin
          row = '{StList, rank_key[i], rank_score[i], CountW'(rank_fill), i == 0};
          row_q = {row_q, row};
        end
      end
    end else begin
      lim = (cap_reg == 0) ? 1 : (cap_reg > Depth) ? Depth : int'(cap_reg);
      hit = -1;
      for (int i = 0; i < rank_fill; i++) begin
        if (rank_key[i] == k) hit = i;
      end
      if (hit >= 0) begin
        if (rank_score[hit] < s) begin
          rank_score[hit] = s;
          resort_ranks();
          st = StRaised;
        end else begin
          st = StNotHigher;
        end
      end else if (rank_fill == 0) begin
        rank_key[0]   = k;
        rank_score[0] = s;
        rank_fill     = 1;
        st            = StAdded;
      end else if (rank_fill >= lim) begin
        if (s > rank_score[0]) begin
          rank_key[0]   = k;
          rank_score[0] = s;
          st            = StReplaced;
        end else begin
          st = StRejected;
        end
        resort_ranks();
      end else begin
        rank_key[rank_fill]   = k;
        rank_score[rank_fill] = s;
        rank_fill++;
        resort_ranks();
        st = StAdded;
      end
      row = '{st, rank_key[0], rank_score[0], CountW'(rank_fill), 1'b1};
      row_q = {row_q, row};
    end
  endfunction

  function automatic void queue_item(op_e o, logic [KeyW-1:0] k, logic signed [ScoreW-1:0] s);
    stim_q = {stim_q, stim_t'{KindItem, o, k, s, '0}};
  endfunction

  function automatic void queue_cap(logic [CapW-1:0] c);
    stim_q = {stim_q, stim_t'{KindWaitIdle, OpAdd, '0, '0, '0}};
    stim_q = {stim_q, stim_t'{KindCapWrite, OpAdd, '0, '0, c}};
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if ((!in_valid || in_taken) && (!cfg_valid || cfg_taken)) begin
        in_taken     = 1'b0;
        cfg_taken    = 1'b0;
        nx_in_valid  = 1'b0;
        nx_cfg_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() > 0) begin
          case (stim_q[0].kind)
            KindItem: begin
              nx_in_valid = 1'b1;
              op         <= stim_q[0].op;
              player_key <= stim_q[0].key;
              score      <= stim_q[0].score;
              void'(stim_q.pop_front());
              if (stim_q.size() > CalmTail && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 15);
              end
            end
            KindCapWrite: begin
              nx_cfg_valid = 1'b1;
              cfg_data <= stim_q[0].cap;
              void'(stim_q.pop_front());
            end
            default: begin
              if (row_q.size() != 0) begin
                settle_left = SettleCyc;
              end else if (settle_left > 0) begin
                settle_left--;
              end else begin
                settle_left = SettleCyc;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
        in_valid  <= nx_in_valid;
        cfg_valid <= nx_cfg_valid;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (stim_q.size() > CalmTail && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        rank_offer(op_e'(op), player_key, score);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        cap_reg   = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (row_q.size() == 0) begin
          errors++;
          $display({"%0t: unexpected item, expected none,",
                    " actual status=%0d key=%h score=%0d count=%0d last=%0b"},
                   $time, status, entry_key, entry_score, entry_count, last);
        end else begin
          got_row = row_q.pop_front();
          if (status !== got_row.status || entry_key !== got_row.key ||
              entry_score !== got_row.score || entry_count !== got_row.count ||
              last !== got_row.last) begin
            errors++;
            $display({"%0t: mismatch, expected status=%0d key=%h score=%0d count=%0d last=%0b,",
                      " actual status=%0d key=%h score=%0d count=%0d last=%0b"},
                     $time, got_row.status, got_row.key, got_row.score, got_row.count,
                     got_row.last, status, entry_key, entry_score, entry_count, last);
          end
        end
      end
    end
  end

  initial begin
    logic [KeyW-1:0]          key_pool [PoolSize];
    logic [KeyW-1:0]          k;
    logic signed [ScoreW-1:0] s;
    logic [CapW-1:0]          c;
    op_e                      o;

    for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;

    queue_item(OpList, '0, '0);
    queue_item(OpAdd, 32'h0000_0000, 32'sh8000_0000);
    queue_item(OpAdd, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    queue_item(OpAdd, 32'h0000_0000, 32'sh8000_0000);
    queue_item(OpAdd, 32'h0000_0000, 32'sd5);
    queue_item(OpAdd, 32'h0000_0000, 32'sd5);
    queue_item(OpAdd, 32'h1234_5678, 32'sd5);
    queue_item(OpList, 32'hFFFF_FFFF, -32'sd1);
    queue_cap(5'd0);
    queue_item(OpAdd, 32'hA5A5_A5A5, 32'sd4);
    queue_item(OpAdd, 32'h5A5A_5A5A, 32'sd6);
    queue_item(OpAdd, 32'hFFFF_FFFF, 32'sd0);
    queue_item(OpAdd, 32'h5A5A_5A5A, 32'sd9);
    queue_item(OpList, '0, '0);
    queue_cap(5'd31);
    for (int i = 0; i < 8; i++) queue_item(OpAdd, key_pool[i], 32'sd6);
    queue_item(OpList, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       c = 5'd16;
        1:       c = 5'd1;
        2:       c = 5'd0;
        3:       c = 5'd31;
        4:       c = 5'd3;
        5:       c = CapW'($urandom_range(1, 16));
        6:       c = 5'd2;
        default: c = 5'd20;
      endcase
      queue_cap(c);
      for (int n = 0; n < 49; n++) begin
        if (n == 26 && ph % 3 == 0) begin
          stim_q = {stim_q, stim_t'{KindWaitIdle, OpAdd, '0, '0, '0}};
        end
        if ($urandom_range(0, 7) == 0) o = OpList;
        else o = OpAdd;
        if ($urandom_range(0, 7) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, PoolSize - 1)];
        case ($urandom_range(0, 9))
          0:          s = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          1, 2, 3, 4: s = $signed($urandom_range(0, 40)) - 20;
          default:    s = $urandom;
        endcase
        queue_item(o, k, s);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (stim_q.size() > 0 || in_valid || cfg_valid) @(posedge clk);
    while (row_q.size() > 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kts_pkg.sv
rtl/keyed_top_k_score_table_core.sv
bench/tb_top.sv
